/* src/adrd_pkg.sv */
// Shared types and constants for the amplitude dropout run detector.
package adrd_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned TOTAL_W = 25;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_STEP = 2'd2;

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic               record_kind;
    logic [FIELD_W-1:0] run_first_sample;
    logic [FIELD_W-1:0] run_final_sample;
    logic [FIELD_W-1:0] run_first_point;
    logic [FIELD_W-1:0] run_final_point;
    logic [TOTAL_W-1:0] dropped_sample_total;
    logic [TOTAL_W-1:0] dropped_point_total;
    logic [TOTAL_W-1:0] point_total;
    logic               final_record;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

/* src/amplitude_dropout_run_detector_unit.sv */
// Output: a sample's records are registered into the result queue and offered from its head.
// Throughput: one sample per cycle while in_ready is high; a sample yields zero, one or
// two records, and the four-entry result queue drops in_ready while it holds more than
// two records. Output stalls hold the queue; no sample is taken unless two entries are free.
// Reset (synchronous, active low): counters, run state and queue clear; registers
// return to threshold 0, minimum run length 1, decimation step 1.
module amplitude_dropout_run_detector_unit #(
  parameter longint unsigned MAX_SAMPLES = 64'd16777216,
  parameter int unsigned     SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [adrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adrd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_record_kind,
  output logic [adrd_pkg::FIELD_W-1:0]  out_run_first_sample,
  output logic [adrd_pkg::FIELD_W-1:0]  out_run_final_sample,
  output logic [adrd_pkg::FIELD_W-1:0]  out_run_first_point,
  output logic [adrd_pkg::FIELD_W-1:0]  out_run_final_point,
  output logic [adrd_pkg::TOTAL_W-1:0]  out_dropped_sample_total,
  output logic [adrd_pkg::TOTAL_W-1:0]  out_dropped_point_total,
  output logic [adrd_pkg::TOTAL_W-1:0]  out_point_total,
  output logic                          out_final_record
);
  import adrd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES - 64'd1);

  logic [THR_W-1:0]   thr_r;
  logic [FIELD_W-1:0] min_run_r;
  logic [FIELD_W-1:0] step_r;
  logic               go;
  logic               has_room;
  push_t              push;
  rec_t               head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      min_run_r <= FIELD_W'(1);
      step_r    <= FIELD_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEVEL_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        REG_MIN_RUN_LENGTH:  min_run_r <= cfg_wdata[FIELD_W-1:0];
        REG_DECIMATION_STEP: step_r    <= cfg_wdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = has_room;
  assign go       = in_valid && has_room;

  adrd_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .CNT_LIMIT  (CNT_LIMIT)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .sample_value   (in_sample_value),
    .last_sample    (in_last_sample),
    .level_threshold(thr_r),
    .min_run_length (min_run_r),
    .decimation_step(step_r),
    .push           (push)
  );

  adrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_valid && out_ready),
    .has_room (has_room),
    .not_empty(out_valid),
    .head     (head)
  );

  assign out_record_kind          = head.record_kind;
  assign out_run_first_sample     = head.run_first_sample;
  assign out_run_final_sample     = head.run_final_sample;
  assign out_run_first_point      = head.run_first_point;
  assign out_run_final_point      = head.run_final_point;
  assign out_dropped_sample_total = head.dropped_sample_total;
  assign out_dropped_point_total  = head.dropped_point_total;
  assign out_point_total          = head.point_total;
  assign out_final_record         = head.final_record;

endmodule

/* src/adrd_core.sv */
// Per-sample run tracking, point mapping and record generation.
module adrd_core #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 24,
  parameter logic [CNT_W-1:0] CNT_LIMIT = '1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [SAMPLE_BITS-1:0]    sample_value,
  input  logic                      last_sample,
  input  logic [adrd_pkg::THR_W-1:0]   level_threshold,
  input  logic [adrd_pkg::FIELD_W-1:0] min_run_length,
  input  logic [adrd_pkg::FIELD_W-1:0] decimation_step,
  output adrd_pkg::push_t           push
);
  import adrd_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int unsigned SUM_W = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
  localparam logic [SUM_W-1:0] SAT25 = SUM_W'({TOTAL_W{1'b1}});

  logic [CNT_W-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic [FIELD_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   point_cnt_r, point_cnt_nxt;
  logic [CNT_W-1:0]   prev_pt_r, prev_pt_nxt;
  logic [CNT_W-1:0]   start_idx_r, start_idx_nxt;
  logic [CNT_W-1:0]   start_pt_r, start_pt_nxt;
  logic [TOTAL_W-1:0] run_len_r, run_len_nxt;
  logic [TOTAL_W-1:0] ds_r, ds_nxt;
  logic [TOTAL_W-1:0] dp_r, dp_nxt;
  logic [CNT_W-1:0]   lmp_r, lmp_nxt;
  logic               marked_r, marked_nxt;

  logic [SAMPLE_BITS-1:0] mag;
  logic                   low;
  logic [FIELD_W-1:0]     minrun, step;
  logic                   close_a, close_b, close;
  logic [CNT_W-1:0]       end_idx, end_pt;
  logic [TOTAL_W-1:0]     run_used, run_len_upd;
  logic [CNT_W:0]         p0;
  logic [SUM_W-1:0]       span, ds_sum, dp_sum, pt_sum;
  logic [TOTAL_W-1:0]     ds_acc, dp_acc, pt_total;
  logic [FIELD_W-1:0]     phase_inc;
  rec_t                   run_rec, sum_rec;

  always_comb begin
    mag    = sample_value[SAMPLE_BITS-1] ? (~sample_value + 1'b1) : sample_value;
    low    = CMP_W'(mag) < CMP_W'(level_threshold);
    minrun = (min_run_length == '0) ? FIELD_W'(1) : min_run_length;
    step   = (decimation_step == '0) ? FIELD_W'(1) : decimation_step;

    // Run length and start bookkeeping
    start_idx_nxt = start_idx_r;
    start_pt_nxt  = start_pt_r;
    close_a       = 1'b0;
    if (low) begin
      if (run_len_r == '0) begin
        start_idx_nxt = sample_cnt_r;
        start_pt_nxt  = point_cnt_r;
      end
      run_len_upd = (run_len_r == '1) ? run_len_r : run_len_r + 1'b1;
    end else begin
      close_a     = run_len_r >= TOTAL_W'(minrun);
      run_len_upd = '0;
    end
    close_b  = last_sample && (run_len_upd >= TOTAL_W'(minrun));
    close    = close_a || close_b;
    run_used = low ? run_len_upd : run_len_r;
    if (close_a) begin
      end_idx = (sample_cnt_r == '0) ? '0 : sample_cnt_r - 1'b1;
      end_pt  = prev_pt_r;
    end else begin
      end_idx = sample_cnt_r;
      end_pt  = point_cnt_r;
    end

    // Totals after a closing run; shared points count once
    ds_sum = SUM_W'(ds_r) + SUM_W'(run_used);
    p0     = (marked_r && (lmp_r >= start_pt_nxt)) ? {1'b0, lmp_r} + 1'b1
                                                   : {1'b0, start_pt_nxt};
    span   = ({1'b0, end_pt} >= p0) ? SUM_W'({1'b0, end_pt} - p0) + 1'b1 : '0;
    dp_sum = SUM_W'(dp_r) + span;
    if (close) begin
      ds_acc = (ds_sum > SAT25) ? '1 : TOTAL_W'(ds_sum);
      dp_acc = (dp_sum > SAT25) ? '1 : TOTAL_W'(dp_sum);
      lmp_nxt    = (!marked_r || (end_pt > lmp_r)) ? end_pt : lmp_r;
      marked_nxt = 1'b1;
    end else begin
      ds_acc     = ds_r;
      dp_acc     = dp_r;
      lmp_nxt    = lmp_r;
      marked_nxt = marked_r;
    end
    pt_sum   = SUM_W'(point_cnt_r) + 1'b1;
    pt_total = (pt_sum > SAT25) ? '1 : TOTAL_W'(pt_sum);

    run_rec = '0;
    run_rec.record_kind      = KIND_RUN;
    run_rec.run_first_sample = FIELD_W'(start_idx_nxt);
    run_rec.run_final_sample = FIELD_W'(end_idx);
    run_rec.run_first_point  = FIELD_W'(start_pt_nxt);
    run_rec.run_final_point  = FIELD_W'(end_pt);

    sum_rec = '0;
    sum_rec.record_kind          = KIND_SUMMARY;
    sum_rec.dropped_sample_total = ds_acc;
    sum_rec.dropped_point_total  = dp_acc;
    sum_rec.point_total          = pt_total;
    sum_rec.final_record         = 1'b1;

    push.count = go ? ({1'b0, close} + {1'b0, last_sample}) : 2'd0;
    push.rec0  = close ? run_rec : sum_rec;
    push.rec1  = sum_rec;

    // Advance the sample and point counters
    phase_inc = phase_r + 1'b1;
    if (last_sample) begin
      sample_cnt_nxt = '0;
      phase_nxt      = '0;
      point_cnt_nxt  = '0;
      prev_pt_nxt    = '0;
      start_idx_nxt  = '0;
      start_pt_nxt   = '0;
      run_len_nxt    = '0;
      ds_nxt         = '0;
      dp_nxt         = '0;
      lmp_nxt        = '0;
      marked_nxt     = 1'b0;
    end else begin
      prev_pt_nxt    = point_cnt_r;
      sample_cnt_nxt = (sample_cnt_r < CNT_LIMIT) ? sample_cnt_r + 1'b1 : sample_cnt_r;
      run_len_nxt    = run_len_upd;
      ds_nxt         = ds_acc;
      dp_nxt         = dp_acc;
      if (phase_inc >= step) begin
        phase_nxt     = '0;
        point_cnt_nxt = (point_cnt_r < CNT_LIMIT) ? point_cnt_r + 1'b1 : point_cnt_r;
      end else begin
        phase_nxt     = phase_inc;
        point_cnt_nxt = point_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '0;
      phase_r      <= '0;
      point_cnt_r  <= '0;
      prev_pt_r    <= '0;
      start_idx_r  <= '0;
      start_pt_r   <= '0;
      run_len_r    <= '0;
      ds_r         <= '0;
      dp_r         <= '0;
      lmp_r        <= '0;
      marked_r     <= 1'b0;
    end else if (go) begin
      sample_cnt_r <= sample_cnt_nxt;
      phase_r      <= phase_nxt;
      point_cnt_r  <= point_cnt_nxt;
      prev_pt_r    <= prev_pt_nxt;
      start_idx_r  <= start_idx_nxt;
      start_pt_r   <= start_pt_nxt;
      run_len_r    <= run_len_nxt;
      ds_r         <= ds_nxt;
      dp_r         <= dp_nxt;
      lmp_r        <= lmp_nxt;
      marked_r     <= marked_nxt;
    end
  end

endmodule

/* src/adrd_queue.sv */
// Result queue: takes up to two records per cycle, hands out one per transfer.
module adrd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  adrd_pkg::push_t push,
  input  logic            pop,
  output logic            has_room,
  output logic            not_empty,
  output adrd_pkg::rec_t  head
);
  import adrd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  rec_t             entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_plus1;

  always_comb begin
    wr_ptr_plus1 = wr_ptr_r + 1'b1;
    wr_ptr_nxt   = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt   = rd_ptr_r + PTR_W'(pop);
    count_nxt    = count_r + CNT_W'(push.count) - CNT_W'(pop);
    has_room     = count_r <= CNT_W'(QDEPTH - 2);
    not_empty    = count_r != '0;
    head         = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_plus1] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/adrd_checker.sv */
// Port-level checks for the dropout detector, bound to the top level.
module adrd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_record_kind,
  input logic [adrd_pkg::FIELD_W-1:0] out_run_first_sample,
  input logic [adrd_pkg::FIELD_W-1:0] out_run_final_point,
  input logic [adrd_pkg::TOTAL_W-1:0] out_dropped_sample_total,
  input logic [adrd_pkg::TOTAL_W-1:0] out_dropped_point_total,
  input logic [adrd_pkg::TOTAL_W-1:0] out_point_total,
  input logic                         out_final_record
);
  import adrd_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Only the summary closes a capture
  a_final_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_record == (out_record_kind == KIND_SUMMARY)))
    else $error("final flag does not match record kind");

  // Run records carry no totals
  a_run_no_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_RUN |->
      out_dropped_sample_total == '0 && out_dropped_point_total == '0 &&
      out_point_total == '0)
    else $error("run record carries summary totals");

  // Summaries carry no run bounds and always count at least one point
  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_SUMMARY |->
      out_run_first_sample == '0 && out_run_final_point == '0 &&
      out_point_total != '0)
    else $error("summary record malformed");

endmodule

bind amplitude_dropout_run_detector_unit adrd_checker u_adrd_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_record_kind         (out_record_kind),
  .out_run_first_sample    (out_run_first_sample),
  .out_run_final_point     (out_run_final_point),
  .out_dropped_sample_total(out_dropped_sample_total),
  .out_dropped_point_total (out_dropped_point_total),
  .out_point_total         (out_point_total),
  .out_final_record        (out_final_record)
);

/* test/amplitude_dropout_run_detector_unit_tb.sv */
// Self-checking testbench for the amplitude dropout run detector: directed table, then random captures.
module amplitude_dropout_run_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adrd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 55;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [FIELD_W-1:0]   COUNT_TOP = 24'hFFFFFF;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [15:0]     in_sample_value = '0;
  logic                   in_last_sample = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_record_kind;
  logic [FIELD_W-1:0]     out_run_first_sample;
  logic [FIELD_W-1:0]     out_run_final_sample;
  logic [FIELD_W-1:0]     out_run_first_point;
  logic [FIELD_W-1:0]     out_run_final_point;
  logic [TOTAL_W-1:0]     out_dropped_sample_total;
  logic [TOTAL_W-1:0]     out_dropped_point_total;
  logic [TOTAL_W-1:0]     out_point_total;
  logic                   out_final_record;

  amplitude_dropout_run_detector_unit dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_sample_value          (in_sample_value),
    .in_last_sample           (in_last_sample),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_record_kind          (out_record_kind),
    .out_run_first_sample     (out_run_first_sample),
    .out_run_final_sample     (out_run_final_sample),
    .out_run_first_point      (out_run_first_point),
    .out_run_final_point      (out_run_final_point),
    .out_dropped_sample_total (out_dropped_sample_total),
    .out_dropped_point_total  (out_dropped_point_total),
    .out_point_total          (out_point_total),
    .out_final_record         (out_final_record)
  );

  // Register copies
  logic [THR_W-1:0]   thr_q = '0;
  logic [FIELD_W-1:0] min_run_q = 24'd1;
  logic [FIELD_W-1:0] step_q = 24'd1;

  // Running state of the capture
  logic [FIELD_W-1:0] smp_idx, phase, pt_idx, prev_pt;
  logic [FIELD_W-1:0] run_first_idx, run_first_pt, marked_pt;
  logic [TOTAL_W-1:0] run_len, drop_smp, drop_pt;
  logic               marked;

  rec_t step_records[$];
  rec_t pending_records[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  rx_calm = 1'b0;
  int  rx_stall = 0;
  int  gap_odds = 3;
  int  low_left = 0;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [15:0]          value;
    logic                 last;
    bit                   typed;
    rec_t                 want;
  } row_t;

  row_t stim_table[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [TOTAL_W-1:0] sat25(logic [TOTAL_W:0] v);
    return v[TOTAL_W] ? '1 : v[TOTAL_W-1:0];
  endfunction

  function automatic rec_t summary_rec(logic [TOTAL_W-1:0] ds, logic [TOTAL_W-1:0] dp,
                                       logic [TOTAL_W-1:0] pts);
    rec_t r;
    r = '0;
    r.record_kind          = KIND_SUMMARY;
    r.dropped_sample_total = ds;
    r.dropped_point_total  = dp;
    r.point_total          = pts;
    r.final_record         = 1'b1;
    return r;
  endfunction

  function automatic string rec_str(rec_t r);
    return $sformatf("kind=%0d smp=%0d..%0d pt=%0d..%0d drop_smp=%0d drop_pt=%0d pts=%0d fin=%0d",
                     r.record_kind, r.run_first_sample, r.run_final_sample,
                     r.run_first_point, r.run_final_point, r.dropped_sample_total,
                     r.dropped_point_total, r.point_total, r.final_record);
  endfunction

  task automatic clear_capture();
    smp_idx = '0;
    phase = '0;
    pt_idx = '0;
    prev_pt = '0;
    run_first_idx = '0;
    run_first_pt = '0;
    run_len = '0;
    drop_smp = '0;
    drop_pt = '0;
    marked_pt = '0;
    marked = 1'b0;
  endtask

  // Account a qualified run and queue its record; shared points count once.
  task automatic close_run(input logic [FIELD_W-1:0] end_idx, input logic [FIELD_W-1:0] end_pt);
    logic [TOTAL_W-1:0] p0;
    rec_t r;
    p0 = {1'b0, run_first_pt};
    drop_smp = sat25({1'b0, drop_smp} + {1'b0, run_len});
    if (marked && {1'b0, marked_pt} >= p0) p0 = {1'b0, marked_pt} + 25'd1;
    if ({1'b0, end_pt} >= p0)
      drop_pt = sat25({1'b0, drop_pt} + {2'b0, end_pt} - {1'b0, p0} + 26'd1);
    if (!marked || end_pt > marked_pt) marked_pt = end_pt;
    marked = 1'b1;
    r = '0;
    r.record_kind      = KIND_RUN;
    r.run_first_sample = run_first_idx;
    r.run_final_sample = end_idx;
    r.run_first_point  = run_first_pt;
    r.run_final_point  = end_pt;
    step_records.push_back(r);
  endtask

  task automatic predict_sample(input logic [15:0] value, input logic last);
    logic [15:0]        mag;
    logic [FIELD_W-1:0] need, stride, idx, pt;
    step_records.delete();
    mag    = value[15] ? ~value + 16'd1 : value;
    need   = (min_run_q == '0) ? 24'd1 : min_run_q;
    stride = (step_q == '0) ? 24'd1 : step_q;
    idx    = smp_idx;
    pt     = pt_idx;
    if (mag < thr_q) begin
      if (run_len == '0) begin
        run_first_idx = idx;
        run_first_pt  = pt;
      end
      run_len = sat25({1'b0, run_len} + 26'd1);
    end else begin
      if (run_len >= {1'b0, need}) close_run((idx != '0) ? idx - 24'd1 : '0, prev_pt);
      run_len = '0;
    end
    if (last) begin
      if (run_len >= {1'b0, need}) close_run(idx, pt);
      step_records.push_back(summary_rec(drop_smp, drop_pt, {1'b0, pt} + 25'd1));
      clear_capture();
    end else begin
      prev_pt = pt;
      if (smp_idx != COUNT_TOP) smp_idx = smp_idx + 24'd1;
      phase = phase + 24'd1;
      if (phase >= stride) begin
        phase = '0;
        if (pt_idx != COUNT_TOP) pt_idx = pt_idx + 24'd1;
      end
    end
  endtask

  task automatic send_sample(input logic [15:0] value, input logic last, input bit typed,
                             input rec_t want);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_last_sample  <= last;
    do @(posedge clk); while (!in_ready);
    predict_sample(value, last);
    if (typed) pending_records.push_back(want);
    else foreach (step_records[i]) pending_records.push_back(step_records[i]);
  endtask

  task automatic sender_gap();
    int n;
    if (no_idle || $urandom_range(0, 9) >= gap_odds) return;
    n = $urandom_range(1, 14);
    @(negedge clk) in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold the sender until every queued record has come out.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_LEVEL_THRESHOLD: thr_q = data[THR_W-1:0];
      REG_MIN_RUN_LENGTH:  min_run_q = data;
      REG_DECIMATION_STEP: step_q = data;
      default: ;
    endcase
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t smp_row(logic [15:0] value, logic last);
    row_t r;
    r = '{default: '0};
    r.value = value;
    r.last  = last;
    return r;
  endfunction

  function automatic row_t sum_row(logic [15:0] value, rec_t want);
    row_t r;
    r = smp_row(value, 1'b1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [15:0] pick_low();
    logic [16:0] top;
    logic [15:0] m;
    top = {1'b0, thr_q} - 17'd1;
    if (top > 17'd32768) top = 17'd32768;
    m = 16'($urandom_range(0, int'(top)));
    return $urandom_range(0, 1) ? ~m + 16'd1 : m;
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] m;
    if (low_left == 0 && thr_q != '0 && $urandom_range(0, 2) == 0)
      low_left = $urandom_range(1, 10);
    if (low_left != 0) begin
      low_left--;
      return pick_low();
    end
    if ($urandom_range(0, 5) == 0) begin
      // straddle the threshold
      m = thr_q - 16'($urandom_range(0, 1));
      return $urandom_range(0, 1) ? ~m + 16'd1 : m;
    end
    return 16'($urandom);
  endfunction

  task automatic pick_settings(input int p);
    logic [THR_W-1:0]   thr;
    logic [FIELD_W-1:0] need, stride;
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = 16'hFFFF;
      2: thr = 16'h8000;
      default: thr = 16'($urandom_range(1, 40000));
    endcase
    case ($urandom_range(0, 7))
      0: need = COUNT_TOP;
      1: need = 24'($urandom);
      default: need = 24'($urandom_range(0, 5));
    endcase
    case ($urandom_range(0, 7))
      0: stride = COUNT_TOP;
      1: stride = 24'($urandom);
      2: stride = 24'($urandom_range(1, 40));
      default: stride = 24'($urandom_range(0, 6));
    endcase
    write_reg(REG_LEVEL_THRESHOLD, {8'($urandom), thr});
    write_reg(REG_MIN_RUN_LENGTH, need);
    write_reg(REG_DECIMATION_STEP, stride);
    if (p == 0) write_reg(REG_SPARE, 24'($urandom));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $realtime,
               pending_records.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, none at the end.
  initial begin
    forever begin
      @(negedge clk);
      if (no_idle || rx_calm) begin
        out_ready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    end
  end

  always @(posedge clk) begin : check_records
    rec_t got;
    rec_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_record_kind, out_run_first_sample, out_run_final_sample,
              out_run_first_point, out_run_final_point, out_dropped_sample_total,
              out_dropped_point_total, out_point_total, out_final_record};
      if (pending_records.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected record, expected none, actual %s", $realtime, rec_str(got));
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: record mismatch, expected %s", $realtime, rec_str(want));
          $display("%0t:                  actual   %s", $realtime, rec_str(got));
        end
      end
    end
  end

  initial begin
    clear_capture();
    stim_table.push_back(sum_row(16'h7FFF, summary_rec(25'd0, 25'd0, 25'd1)));
    stim_table.push_back(cfg_row(REG_LEVEL_THRESHOLD, 24'h008000));
    stim_table.push_back(cfg_row(REG_MIN_RUN_LENGTH, 24'd0));
    stim_table.push_back(cfg_row(REG_DECIMATION_STEP, 24'd0));
    stim_table.push_back(smp_row(16'h8000, 1'b0));
    stim_table.push_back(smp_row(16'h0000, 1'b0));
    stim_table.push_back(smp_row(16'h7FFF, 1'b0));
    stim_table.push_back(smp_row(16'h8001, 1'b0));
    stim_table.push_back(smp_row(16'h8000, 1'b0));
    stim_table.push_back(smp_row(16'd100, 1'b0));
    stim_table.push_back(smp_row(16'd5, 1'b1));
    stim_table.push_back(cfg_row(REG_LEVEL_THRESHOLD, 24'd100));
    stim_table.push_back(cfg_row(REG_MIN_RUN_LENGTH, 24'd3));
    stim_table.push_back(cfg_row(REG_DECIMATION_STEP, 24'd4));
    stim_table.push_back(smp_row(16'd50, 1'b0));
    stim_table.push_back(smp_row(-16'sd50, 1'b0));
    stim_table.push_back(smp_row(16'd200, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd300, 1'b0));
    // next run shares point 1 with the previous one
    stim_table.push_back(smp_row(-16'sd99, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd99, 1'b0));
    stim_table.push_back(smp_row(-16'sd100, 1'b0));
    stim_table.push_back(smp_row(16'd5, 1'b1));
    stim_table.push_back(cfg_row(REG_LEVEL_THRESHOLD, 24'hFFFFFF));
    stim_table.push_back(cfg_row(REG_MIN_RUN_LENGTH, COUNT_TOP));
    stim_table.push_back(cfg_row(REG_DECIMATION_STEP, COUNT_TOP));
    stim_table.push_back(smp_row(16'h7FFF, 1'b0));
    stim_table.push_back(sum_row(16'h8000, summary_rec(25'd0, 25'd0, 25'd1)));
    stim_table.push_back(cfg_row(REG_LEVEL_THRESHOLD, 24'd16));
    stim_table.push_back(cfg_row(REG_MIN_RUN_LENGTH, 24'd1));
    stim_table.push_back(cfg_row(REG_DECIMATION_STEP, 24'd8));
    stim_table.push_back(smp_row(16'd1, 1'b0));
    stim_table.push_back(smp_row(16'd2, 1'b0));
    stim_table.push_back(smp_row(16'd3, 1'b0));
    stim_table.push_back(smp_row(16'd100, 1'b0));
    // shrink the step below the current phase, mid capture
    stim_table.push_back(cfg_row(REG_DECIMATION_STEP, 24'd2));
    stim_table.push_back(smp_row(16'd0, 1'b0));
    stim_table.push_back(smp_row(16'd0, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        wait_idle();
        write_reg(stim_table[i].idx, stim_table[i].data);
      end else begin
        send_sample(stim_table[i].value, stim_table[i].last, stim_table[i].typed,
                    stim_table[i].want);
        sender_gap();
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      pick_settings(p);
      no_idle  = (p == RANDOM_PHASES - 1);
      gap_odds = $urandom_range(0, 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == 27) wait_idle();
        send_sample(pick_sample(),
                    (no_idle && k == PHASE_ITEMS - 1) || $urandom_range(0, 19) == 0,
                    1'b0, '0);
        sender_gap();
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
